### sv/byte_guard_watch_unit_defines.svh
// assertion macros shared by the guard unit rtl
`ifndef BYTE_GUARD_WATCH_UNIT_DEFINES_SVH
`define BYTE_GUARD_WATCH_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BGW_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define BGW_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/bgw_pkg.sv
// types and codes of the byte guard watch unit
package bgw_pkg;

    localparam int START_W = 20;
    localparam int COUNT_W = 16;
    localparam int TAG_W   = 16;
    localparam int OFF_W   = 5;

    localparam logic [1:0] MODE_SET     = 2'd0;
    localparam logic [1:0] MODE_DISMISS = 2'd1;
    localparam logic [1:0] MODE_CHECK   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic [START_W-1:0] start_addr;
        logic [COUNT_W-1:0] byte_count;
        logic [TAG_W-1:0]   marker;
    } t_cmd;

    typedef struct packed {
        logic       guarded;
        logic [1:0] status;
    } t_res;

    typedef struct packed {
        logic [START_W-1:0] start;
        logic [COUNT_W-1:0] length;
        logic [TAG_W-1:0]   tag;
    } t_descr;

endpackage

### sv/bgw_ram.sv
// generic single-write, single-read ram with registered read
module bgw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### sv/byte_guard_watch_unit.sv
// byte guard watch unit: guard bitmap, descriptor table and command sequencer
//
// Commands come in on i_cmd and are taken at a clock edge with start high and
// busy low. Mode set guard marks the bytes of a range and appends a descriptor,
// dismiss guard looks a descriptor up by start address, fills its slot with the
// last one and clears its bytes, check access tests for any guarded byte.
// Every command gives one result beat on o_res, marked by o_done for one cycle;
// the receiver takes it and cannot stall. busy drops in the cycle of o_done,
// so the next command may be taken while the result is shown.
// Each command is accepted in idle, then the bitmap words of its range are visited
// through a read-modify-write loop on the single bitmap ram port pair.
// Table full, unused mode and empty ranges are answered from idle.
// Dismiss first scans the descriptors, then moves the last entry into the slot
// and sets up the range before its walk.
// After reset the bitmap ram is swept to zero, one word a cycle, with busy high;
// the descriptor table is emptied at once.
module byte_guard_watch_unit #(
    parameter int ADDR_BITS     = 20,
    parameter int DESCR_ENTRIES = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  bgw_pkg::t_cmd   i_cmd,
    output logic            o_done,
    output bgw_pkg::t_res   o_res
);
    `include "byte_guard_watch_unit_defines.svh"

    localparam int WW      = ADDR_BITS - 5;
    localparam int BM_DEP  = 1 << WW;
    localparam int IW      = DESCR_ENTRIES > 1 ? $clog2(DESCR_ENTRIES) : 1;
    localparam int CW      = $clog2(DESCR_ENTRIES + 1);
    localparam int DW      = $bits(bgw_pkg::t_descr);
    localparam int XW      = (ADDR_BITS > bgw_pkg::START_W ? ADDR_BITS : bgw_pkg::START_W) + 1;
    localparam logic [XW-1:0] MEM_END = XW'(1) << ADDR_BITS;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_SCAN  = 6'b000100,
        S_MOVE  = 6'b001000,
        S_PREP  = 6'b010000,
        S_WALK  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [WW-1:0] r_word, n_word, r_lo_w, n_lo_w, r_last_w, n_last_w;
    logic [bgw_pkg::OFF_W-1:0] r_lo_off, n_lo_off, r_hi_off, n_hi_off;
    logic [1:0] r_op, n_op;
    logic r_any, n_any;
    logic [bgw_pkg::START_W-1:0] r_lo, n_lo;
    logic [bgw_pkg::COUNT_W-1:0] r_len, n_len;
    logic [IW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_count, n_count;
    logic r_done, n_done;
    bgw_pkg::t_res r_res, n_res;

    // bitmap ram
    logic bm_we;
    logic [WW-1:0] bm_waddr, bm_raddr;
    logic [31:0] bm_wdata, bm_rdata;

    // descriptor ram
    logic d_we;
    logic [IW-1:0] d_waddr, d_raddr;
    bgw_pkg::t_descr d_wdata, d_rdata;

    bgw_ram #(.WIDTH(32), .DEPTH(BM_DEP)) u_bitmap (
        .i_clk  (i_clk),
        .i_we   (bm_we),
        .i_waddr(bm_waddr),
        .i_wdata(bm_wdata),
        .i_raddr(bm_raddr),
        .o_rdata(bm_rdata)
    );

    bgw_ram #(.WIDTH(DW), .DEPTH(DESCR_ENTRIES)) u_descr (
        .i_clk  (i_clk),
        .i_we   (d_we),
        .i_waddr(d_waddr),
        .i_wdata(d_wdata),
        .i_raddr(d_raddr),
        .o_rdata(d_rdata)
    );

    // range clipping, fed by the command in idle and by the dismissed entry later
    logic [bgw_pkg::START_W-1:0] sp_lo;
    logic [bgw_pkg::COUNT_W-1:0] sp_len;
    logic [XW-1:0] lo_x, hi_x, hi_c, last_x;
    logic sp_empty;

    always_comb begin
        sp_lo    = (r_state == S_IDLE) ? i_cmd.start_addr : r_lo;
        sp_len   = (r_state == S_IDLE) ? i_cmd.byte_count : r_len;
        lo_x     = XW'(sp_lo);
        hi_x     = lo_x + XW'(sp_len);
        hi_c     = (hi_x > MEM_END) ? MEM_END : hi_x;
        last_x   = hi_c - XW'(1);
        sp_empty = (lo_x >= MEM_END) || (sp_len == '0);
    end

    // word mask for the current walk position
    logic [bgw_pkg::OFF_W-1:0] lo_a, hi_b;
    logic [31:0] mask;
    logic hit, walk_last, full, match;
    logic [IW-1:0] last_idx;

    always_comb begin
        lo_a      = (r_word == r_lo_w) ? r_lo_off : '0;
        hi_b      = (r_word == r_last_w) ? r_hi_off : '1;
        mask      = ({32{1'b1}} << lo_a) & ({32{1'b1}} >> (5'd31 - hi_b));
        hit       = |(bm_rdata & mask);
        walk_last = (r_word == r_last_w);
        full      = (r_count == CW'(DESCR_ENTRIES));
        last_idx  = IW'(r_count - CW'(1));
        match     = (d_rdata.start == r_lo);
    end

    always_comb begin
        n_state  = r_state;
        n_word   = r_word;
        n_lo_w   = r_lo_w;
        n_last_w = r_last_w;
        n_lo_off = r_lo_off;
        n_hi_off = r_hi_off;
        n_op     = r_op;
        n_any    = r_any;
        n_lo     = r_lo;
        n_len    = r_len;
        n_idx    = r_idx;
        n_count  = r_count;
        n_done   = 1'b0;
        n_res    = r_res;
        bm_we    = 1'b0;
        bm_waddr = r_word;
        bm_wdata = '0;
        bm_raddr = r_word + WW'(1);
        d_we     = 1'b0;
        d_waddr  = r_idx;
        d_wdata  = d_rdata;
        d_raddr  = r_idx;

        unique case (r_state)
            S_CLEAR: begin
                bm_we  = 1'b1;
                n_word = r_word + WW'(1);
                if (r_word == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                bm_raddr = lo_x[ADDR_BITS-1:5];
                d_raddr  = '0;
                n_lo_w   = lo_x[ADDR_BITS-1:5];
                n_word   = lo_x[ADDR_BITS-1:5];
                n_last_w = last_x[ADDR_BITS-1:5];
                n_lo_off = lo_x[4:0];
                n_hi_off = last_x[4:0];
                n_op     = i_cmd.mode;
                n_any    = 1'b0;
                n_lo     = i_cmd.start_addr;
                n_idx    = '0;
                if (start) begin
                    n_res = '{guarded: 1'b0, status: bgw_pkg::ST_OK};
                    priority if (i_cmd.mode == bgw_pkg::MODE_SET) begin
                        if (full) begin
                            n_res.status = bgw_pkg::ST_FULL;
                            n_done       = 1'b1;
                        end else begin
                            d_we    = 1'b1;
                            d_waddr = IW'(r_count);
                            d_wdata = '{start: i_cmd.start_addr,
                                        length: i_cmd.byte_count,
                                        tag: i_cmd.marker};
                            n_count = r_count + CW'(1);
                            if (sp_empty) n_done = 1'b1;
                            else          n_state = S_WALK;
                        end
                    end else if (i_cmd.mode == bgw_pkg::MODE_DISMISS) begin
                        if (r_count == '0) begin
                            n_res.status = bgw_pkg::ST_NOT_FOUND;
                            n_done       = 1'b1;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else if (i_cmd.mode == bgw_pkg::MODE_CHECK) begin
                        if (sp_empty) n_done = 1'b1;
                        else          n_state = S_WALK;
                    end else begin
                        n_done = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                if (match) begin
                    // fetch the last entry to fill the hole
                    n_len   = d_rdata.length;
                    d_raddr = last_idx;
                    n_state = S_MOVE;
                end else if (r_idx == last_idx) begin
                    n_res.status = bgw_pkg::ST_NOT_FOUND;
                    n_done       = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_idx   = r_idx + IW'(1);
                    d_raddr = r_idx + IW'(1);
                end
            end
            S_MOVE: begin
                d_we    = 1'b1;
                d_waddr = r_idx;
                d_wdata = d_rdata;
                n_count = r_count - CW'(1);
                n_state = S_PREP;
            end
            S_PREP: begin
                bm_raddr = lo_x[ADDR_BITS-1:5];
                n_lo_w   = lo_x[ADDR_BITS-1:5];
                n_word   = lo_x[ADDR_BITS-1:5];
                n_last_w = last_x[ADDR_BITS-1:5];
                n_lo_off = lo_x[4:0];
                n_hi_off = last_x[4:0];
                if (sp_empty) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                // read of the next word overlaps the write-back of this one
                bm_we    = (r_op != bgw_pkg::MODE_CHECK);
                bm_wdata = (r_op == bgw_pkg::MODE_SET) ? (bm_rdata | mask)
                                                        : (bm_rdata & ~mask);
                n_any    = r_any | hit;
                n_word   = r_word + WW'(1);
                if (walk_last) begin
                    n_res.guarded = (r_op == bgw_pkg::MODE_CHECK) && (r_any | hit);
                    n_done        = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_word  <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_word  <= n_word;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo_w   <= n_lo_w;
        r_last_w <= n_last_w;
        r_lo_off <= n_lo_off;
        r_hi_off <= n_hi_off;
        r_op     <= n_op;
        r_any    <= n_any;
        r_lo     <= n_lo;
        r_len    <= n_len;
        r_idx    <= n_idx;
        r_res    <= n_res;
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;

    `BGW_ASSERT_IMP(a_no_rw_same_word, i_clk, i_rst_n, bm_we, bm_raddr != bm_waddr,
        "bitmap read and write hit the same word")
    `BGW_ASSERT_IMP(a_append_not_full, i_clk, i_rst_n, d_we && (r_state == S_IDLE),
        r_count < CW'(DESCR_ENTRIES), "descriptor appended to a full table")
    `BGW_ASSERT_IMP(a_walk_in_range, i_clk, i_rst_n, r_state == S_WALK,
        r_word <= r_last_w, "walk passed the last word of the range")
    `BGW_ASSERT_NXT(a_move_shrinks, i_clk, i_rst_n, r_state == S_MOVE,
        r_count == $past(r_count) - CW'(1), "slot move did not shrink the table")
endmodule
